// ===== hdl/ffmp_pkg.sv =====
package ffmp_pkg;

	// byte codes of the framing
	localparam logic [7:0] OPEN_MARK  = 8'h3C;
	localparam logic [7:0] CLOSE_MARK = 8'h3E;
	localparam logic [7:0] SEP_MARK   = 8'h23;
	localparam logic [7:0] PLUS_MARK  = 8'h2B;
	localparam logic [7:0] MINUS_MARK = 8'h2D;
	localparam logic [7:0] ZERO_MARK  = 8'h30;
	localparam logic [7:0] NINE_MARK  = 8'h39;
	localparam logic [7:0] SPACE_MARK = 8'h20;
	localparam logic [7:0] TAB_MARK   = 8'h09;
	localparam logic [7:0] CR_MARK    = 8'h0D;

	// configuration register widths and indexes
	localparam int FIELD_W = 5;
	localparam int MATCH_W = 18;
	localparam int CFG_W   = 18;
	localparam logic REG_TARGET_FIELD = 1'b0;
	localparam logic REG_MATCH_VALUE  = 1'b1;

	// reset values of the registers
	localparam logic [FIELD_W-1:0]        TARGET_RESET = 5'd4;
	localparam logic signed [MATCH_W-1:0] MATCH_RESET  = 18'sd120;

	typedef enum logic [1:0] {
		KIND_OPEN,
		KIND_CLOSE,
		KIND_SEP,
		KIND_DATA
	} byte_kind_t;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_DIGITS,
		PH_STOP
	} conv_phase_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data;
		byte_kind_t kind;
		logic       is_space;
		logic       is_sign;
		logic       is_minus;
		logic       is_digit;
		logic [3:0] digit;
	} byte_info_t;

	// bits needed to hold 10**n - 1
	function automatic int digits_width(input int n);
		longint p;
		int w;
		p = 1;
		w = 0;
		for (int i = 0; i < n; i++) p = p * 10;
		while ((longint'(1) << w) < p) w++;
		return (w < 1) ? 1 : w;
	endfunction

endpackage

// ===== hdl/ffmp_front.sv =====
module ffmp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	output logic                q_valid,
	input  logic                q_ready,
	output ffmp_pkg::byte_info_t q_info
);
	import ffmp_pkg::*;

	logic       valid_s1;
	byte_info_t info_s1;
	byte_info_t info_c;

	// classify the received byte
	always_comb begin
		info_c.data = s_tdata;
		unique case (s_tdata)
			OPEN_MARK:  info_c.kind = KIND_OPEN;
			CLOSE_MARK: info_c.kind = KIND_CLOSE;
			SEP_MARK:   info_c.kind = KIND_SEP;
			default:    info_c.kind = KIND_DATA;
		endcase
		info_c.is_space = (s_tdata == SPACE_MARK) ||
			((s_tdata >= TAB_MARK) && (s_tdata <= CR_MARK));
		info_c.is_sign  = (s_tdata == PLUS_MARK) || (s_tdata == MINUS_MARK);
		info_c.is_minus = (s_tdata == MINUS_MARK);
		info_c.is_digit = (s_tdata >= ZERO_MARK) && (s_tdata <= NINE_MARK);
		info_c.digit    = 4'(s_tdata - ZERO_MARK);
	end

	assign s_tready = !valid_s1 || q_ready;

	// holding stage in front of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			info_s1 <= info_c;
		end
	end

	assign q_valid = valid_s1;
	assign q_info  = info_s1;

endmodule

// ===== hdl/ffmp_queue.sv =====
module ffmp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ffmp_pkg::byte_info_t in_info,
	output logic                out_valid,
	input  logic                out_ready,
	output ffmp_pkg::byte_info_t out_info
);
	import ffmp_pkg::*;

	byte_info_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_info  = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_info;
		end
	end

endmodule

// ===== hdl/ffmp_back.sv =====
module ffmp_back #(
	parameter int FRAME_STORE_DEPTH = 32,
	parameter int MAX_FIELD_CHARS   = 5,
	parameter int MAX_FIELDS        = 25
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ffmp_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ffmp_pkg::byte_info_t       in_info,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 echo_byte,
	output logic                       frame_done,
	output logic                       pin_high
);
	import ffmp_pkg::*;

	localparam int SC_W  = $clog2(FRAME_STORE_DEPTH);
	localparam int FN_W  = $clog2(MAX_FIELDS + 1);
	localparam int CC_W  = $clog2(MAX_FIELD_CHARS + 1);
	localparam int VAL_W = digits_width(MAX_FIELD_CHARS);
	localparam int CMP_W = (VAL_W + 1 > MATCH_W) ? VAL_W + 1 : MATCH_W;

	logic [FIELD_W-1:0]        target_field_q;
	logic signed [MATCH_W-1:0] match_value_q;

	logic              in_frame_q,  in_frame_d;
	logic [SC_W-1:0]   stored_q,    stored_d;
	logic [FN_W-1:0]   field_q,     field_d;
	logic [CC_W-1:0]   char_q,      char_d;
	conv_phase_t       phase_q,     phase_d;
	logic              neg_q,       neg_d;
	logic [VAL_W-1:0]  value_q,     value_d;
	logic              pin_q,       pin_d;
	logic              done_d;

	logic              valid_q;
	logic [7:0]        echo_q;
	logic              done_q;

	logic              pop;
	logic              capture;
	logic [VAL_W+3:0]  times_ten;
	logic signed [CMP_W-1:0] value_ext;
	logic signed [CMP_W-1:0] conv_result;
	logic signed [CMP_W-1:0] match_ext;

	assign in_ready = !valid_q || out_ready;
	assign pop      = in_valid && in_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_field_q <= TARGET_RESET;
			match_value_q  <= MATCH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_FIELD: target_field_q <= cfg_wdata[FIELD_W-1:0];
				REG_MATCH_VALUE:  match_value_q  <= signed'(cfg_wdata[MATCH_W-1:0]);
				default: ;
			endcase
		end
	end

	// signed value of the converted text and of the match register
	assign value_ext   = signed'(CMP_W'(value_q));
	assign conv_result = neg_q ? -value_ext : value_ext;
	assign match_ext   = CMP_W'(match_value_q);
	assign times_ten   = ({value_q, 3'b000} + {2'b00, value_q, 1'b0}) +
		(VAL_W+4)'(in_info.digit);

	// frame bookkeeping for one byte
	always_comb begin
		in_frame_d = in_frame_q;
		stored_d   = stored_q;
		field_d    = field_q;
		char_d     = char_q;
		pin_d      = pin_q;
		done_d     = 1'b0;
		capture    = 1'b0;
		if (!in_frame_q) begin
			if (in_info.kind == KIND_OPEN) begin
				in_frame_d = 1'b1;
				stored_d   = '0;
				field_d    = '0;
				char_d     = '0;
			end
		end else if (in_info.kind == KIND_CLOSE) begin
			in_frame_d = 1'b0;
			pin_d      = (conv_result == match_ext);
			done_d     = 1'b1;
			stored_d   = '0;
			field_d    = '0;
			char_d     = '0;
		end else if (stored_q < SC_W'(FRAME_STORE_DEPTH - 1)) begin
			stored_d = stored_q + SC_W'(1);
			if ((char_q < CC_W'(MAX_FIELD_CHARS)) && (field_q < FN_W'(MAX_FIELDS))) begin
				if (in_info.kind == KIND_SEP) begin
					field_d = field_q + FN_W'(1);
					char_d  = '0;
				end else if (FIELD_W'(field_q) == target_field_q) begin
					char_d  = char_q + CC_W'(1);
					capture = 1'b1;
				end
			end
		end
	end

	// text conversion, one captured character at a time
	always_comb begin
		phase_d = phase_q;
		neg_d   = neg_q;
		value_d = value_q;
		if (done_d || (!in_frame_q && in_info.kind == KIND_OPEN)) begin
			phase_d = PH_SKIP;
			neg_d   = 1'b0;
			value_d = '0;
		end else if (capture) begin
			unique case (phase_q)
				PH_SKIP: begin
					if (in_info.is_space) begin
						phase_d = PH_SKIP;
					end else if (in_info.is_sign) begin
						phase_d = PH_DIGITS;
						neg_d   = in_info.is_minus;
					end else if (in_info.is_digit) begin
						phase_d = PH_DIGITS;
						value_d = VAL_W'(in_info.digit);
					end else begin
						phase_d = PH_STOP;
					end
				end
				PH_DIGITS: begin
					if (in_info.is_digit) begin
						value_d = times_ten[VAL_W-1:0];
					end else begin
						phase_d = PH_STOP;
					end
				end
				PH_STOP: phase_d = PH_STOP;
				default: phase_d = PH_STOP;
			endcase
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			stored_q   <= '0;
			field_q    <= '0;
			char_q     <= '0;
			phase_q    <= PH_SKIP;
			neg_q      <= 1'b0;
			value_q    <= '0;
			pin_q      <= 1'b0;
		end else if (pop) begin
			in_frame_q <= in_frame_d;
			stored_q   <= stored_d;
			field_q    <= field_d;
			char_q     <= char_d;
			phase_q    <= phase_d;
			neg_q      <= neg_d;
			value_q    <= value_d;
			pin_q      <= pin_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			echo_q <= in_info.data;
			done_q <= done_d;
		end
	end

	assign out_valid  = valid_q;
	assign echo_byte  = echo_q;
	assign frame_done = done_q;
	assign pin_high   = pin_q;

endmodule

// ===== hdl/framed_field_match_parser.sv =====
// path: holding stage, then two-entry queue, then output register, to the master side
// throughput: one byte per cycle unless m_tready stalls; holding stage and output register
// take a new byte while the one ahead is being taken, the two-entry queue whenever not full
// conversion runs one captured character per byte, so a closing byte adds no stall
// reset: arst_n clears the frame state and the pin, and loads target_field 4, match_value 120
module framed_field_match_parser #(
	parameter int FRAME_STORE_DEPTH = 32,
	parameter int MAX_FIELD_CHARS   = 5,
	parameter int MAX_FIELDS        = 25
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [ffmp_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // rx_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [15:0]                m_tdata,   // echo_byte [7:0], pin_high [8], zeros
	output logic                       m_tlast    // frame_done
);
	import ffmp_pkg::*;

	logic       fq_valid;
	logic       fq_ready;
	byte_info_t fq_info;
	logic       qb_valid;
	logic       qb_ready;
	byte_info_t qb_info;
	logic [7:0] echo_byte;
	logic       pin_high;

	// front: accept and classify
	ffmp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_info   (fq_info)
	);

	// decoupling queue
	ffmp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_info   (fq_info),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_info  (qb_info)
	);

	// back: frame parsing, conversion and pin
	ffmp_back #(
		.FRAME_STORE_DEPTH (FRAME_STORE_DEPTH),
		.MAX_FIELD_CHARS   (MAX_FIELD_CHARS),
		.MAX_FIELDS        (MAX_FIELDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (qb_valid),
		.in_ready   (qb_ready),
		.in_info    (qb_info),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.echo_byte  (echo_byte),
		.frame_done (m_tlast),
		.pin_high   (pin_high)
	);

	assign m_tdata = {7'b0000000, pin_high, echo_byte};

endmodule

// ===== dv/framed_field_match_parser_test.sv =====
`timescale 1ns / 100ps

module framed_field_match_parser_test;
	import ffmp_pkg::*;

	localparam int STORE_DEPTH  = 32;
	localparam int FIELD_CHARS  = 5;
	localparam int FIELD_LIMIT  = 25;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 2000;

	typedef struct packed {
		logic [7:0] echo;
		logic       done;
		logic       pin;
	} parse_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // rx_byte
	logic              m_tvalid;
	logic              m_tready;
	logic [15:0]       m_tdata;   // echo_byte [7:0], pin_high [8], zeros
	logic              m_tlast;   // frame_done

	// predicted parser state and register copies
	logic                        pr_open;
	int                          pr_kept;
	int                          pr_seps;
	int                          pr_nchar;
	int                          pr_caplen;
	logic [7:0]                  pr_text [FIELD_CHARS];
	logic                        pr_pin;
	logic [FIELD_W-1:0]          pr_field;
	logic signed [MATCH_W-1:0]   pr_match;

	parse_result_t pending_results [$];
	int            fail_count;
	logic          no_idle;

	framed_field_match_parser DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// gap length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(15, 40);
	endfunction

	// random field content, never a separator or a closing mark
	function automatic logic [7:0] filler_byte();
		logic [7:0] b;
		case ($urandom_range(0, 5))
			0, 1: b = ZERO_MARK + 8'($urandom_range(0, 9));
			2: b = $urandom_range(0, 1) ? SPACE_MARK : TAB_MARK + 8'($urandom_range(0, 4));
			3: b = $urandom_range(0, 1) ? PLUS_MARK : MINUS_MARK;
			default: begin
				b = 8'($urandom_range(0, 255));
				if (b == SEP_MARK || b == CLOSE_MARK) b = 8'h41;
			end
		endcase
		return b;
	endfunction

	function automatic void clear_frame_state();
		pr_kept   = 0;
		pr_seps   = 0;
		pr_nchar  = 0;
		pr_caplen = 0;
	endfunction

	// next result of the parser for one received byte
	function automatic parse_result_t step_parser(input logic [7:0] c);
		parse_result_t r;
		int i;
		int v;
		logic neg;
		r.done = 1'b0;
		if (!pr_open) begin
			if (c == OPEN_MARK) begin
				pr_open = 1'b1;
				clear_frame_state();
			end
		end else if (c == CLOSE_MARK) begin
			// atoi over the captured text
			i = 0;
			v = 0;
			neg = 1'b0;
			while (i < pr_caplen && (pr_text[i] == SPACE_MARK ||
					(pr_text[i] >= TAB_MARK && pr_text[i] <= CR_MARK)))
				i++;
			if (i < pr_caplen && (pr_text[i] == PLUS_MARK || pr_text[i] == MINUS_MARK)) begin
				neg = (pr_text[i] == MINUS_MARK);
				i++;
			end
			while (i < pr_caplen && pr_text[i] >= ZERO_MARK && pr_text[i] <= NINE_MARK) begin
				v = v * 10 + (int'(pr_text[i]) - int'(ZERO_MARK));
				i++;
			end
			if (neg) v = -v;
			pr_open = 1'b0;
			pr_pin  = (v == int'(pr_match));
			r.done  = 1'b1;
			clear_frame_state();
		end else if (pr_kept < STORE_DEPTH - 1) begin
			pr_kept++;
			if (pr_nchar < FIELD_CHARS && pr_seps < FIELD_LIMIT) begin
				if (c == SEP_MARK) begin
					pr_seps++;
					pr_nchar = 0;
				end else if (pr_seps == int'(pr_field)) begin
					pr_text[pr_nchar] = c;
					pr_nchar++;
					pr_caplen = pr_nchar;
				end
			end
		end
		r.echo = c;
		r.pin  = pr_pin;
		return r;
	endfunction

	// one byte transfer on the slave side
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_results.push_back(step_parser(b));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]));
	endtask

	// hold the sender until every result is back
	task automatic wait_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		if (idx == REG_TARGET_FIELD) pr_field = data[FIELD_W-1:0];
		else pr_match = data[MATCH_W-1:0];
	endtask

	// new settings, written only with the block idle
	task automatic set_config(input logic [CFG_W-1:0] field_word, input int match_val);
		wait_results();
		write_reg(REG_TARGET_FIELD, field_word);
		write_reg(REG_MATCH_VALUE, match_val[CFG_W-1:0]);
		cfg_we <= 1'b0;
	endtask

	// frames with random content, plus noise and broken frames
	task automatic run_frames(input int item_count);
		int sent;
		int nf;
		int len;
		string num;
		logic [7:0] body [$];
		sent = 0;
		while (sent < item_count) begin
			body.delete();
			case ($urandom_range(0, 9))
				7: begin
					repeat ($urandom_range(1, 4)) body.push_back(8'($urandom_range(0, 255)));
				end
				8: begin
					// long frame that can run past the store depth
					body.push_back(OPEN_MARK);
					repeat ($urandom_range(28, 40))
						body.push_back(($urandom_range(0, 3) == 0) ? SEP_MARK : filler_byte());
					body.push_back(CLOSE_MARK);
				end
				9: begin
					// stray close, then a frame left open with an open mark inside
					body.push_back(CLOSE_MARK);
					body.push_back(OPEN_MARK);
					body.push_back(OPEN_MARK);
					repeat ($urandom_range(0, 3)) body.push_back(filler_byte());
				end
				default: begin
					body.push_back(OPEN_MARK);
					if (pr_field >= FIELD_LIMIT) nf = $urandom_range(20, 28);
					else if ($urandom_range(0, 3) == 0) nf = $urandom_range(0, pr_field);
					else nf = pr_field + $urandom_range(0, 2);
					for (int f = 0; f <= nf; f++) begin
						if (f > 0) body.push_back(SEP_MARK);
						if (f == pr_field && $urandom_range(0, 9) < 7) begin
							// text that should convert to the match value
							num = $sformatf("%0d", int'(pr_match));
							if ($urandom_range(0, 3) == 0)
								body.push_back($urandom_range(0, 1) ? SPACE_MARK : TAB_MARK);
							if (pr_match >= 0 && $urandom_range(0, 3) == 0) body.push_back(PLUS_MARK);
							for (int i = 0; i < num.len(); i++) body.push_back(8'(num[i]));
						end else begin
							len = (nf > 8) ? $urandom_range(0, 1) : $urandom_range(0, 7);
							repeat (len) body.push_back(filler_byte());
						end
					end
					body.push_back(CLOSE_MARK);
				end
			endcase
			foreach (body[k]) send_byte(body[k]);
			sent += body.size();
		end
	endtask

	// extremes, marks out of place, signs, blanks and a full capture
	task automatic test_directed_cases();
		set_config(18'd0, 120);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CLOSE_MARK);
		send_text("<120>");
		send_text("<<12>");
		send_text("< +120x>");
		send_text("<#>");
	endtask

	task automatic test_first_field();
		set_config(18'd0, $urandom_range(0, 999));
		run_frames(130);
	endtask

	task automatic test_reset_settings_no_idle();
		set_config({13'h1FFF, TARGET_RESET}, int'(MATCH_RESET));
		no_idle = 1'b1;
		run_frames(90);
		no_idle = 1'b0;
	endtask

	task automatic test_last_field();
		set_config(18'd24, 99999);
		run_frames(120);
	endtask

	task automatic test_unreachable_field();
		set_config(18'($urandom_range(FIELD_LIMIT, 31)), 0);
		run_frames(40);
		set_config(18'd31, 0);
		run_frames(40);
	endtask

	task automatic test_negative_match();
		set_config(18'($urandom_range(0, 7)), -9999);
		run_frames(130);
	endtask

	task automatic test_mixed_settings();
		repeat (4) begin
			set_config({13'($urandom_range(0, 8191)), 5'($urandom_range(0, 31))},
				$urandom_range(0, 109998) - 9999);
			run_frames(45);
		end
	endtask

	// receiver stalls
	initial begin : ready_drive
		int hold;
		m_tready <= 1'b0;
		hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				hold = idle_len();
				m_tready <= (hold == 0);
				if (hold > 0) hold--;
			end
		end
	end

	// compare each master-side transfer with the oldest prediction
	always @(posedge clk) begin : result_check
		parse_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: echo_byte %02h", m_tdata[7:0]);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[7:0] !== want.echo) begin
					$error("echo_byte: expected %02h, got %02h", want.echo, m_tdata[7:0]);
					fail_count++;
				end
				if (m_tlast !== want.done) begin
					$error("frame_done: expected %0b, got %0b", want.done, m_tlast);
					fail_count++;
				end
				if (m_tdata[8] !== want.pin) begin
					$error("pin_high: expected %0b, got %0b", want.pin, m_tdata[8]);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("framed_field_match_parser verification failed");
		$finish;
	end

	// main sequence
	initial begin : main_seq
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_TARGET_FIELD;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'h00;
		fail_count = 0;
		no_idle    = 1'b0;
		pr_open    = 1'b0;
		pr_pin     = 1'b0;
		pr_field   = TARGET_RESET;
		pr_match   = MATCH_RESET;
		clear_frame_state();
		foreach (pr_text[i]) pr_text[i] = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_first_field();
		test_reset_settings_no_idle();
		test_last_field();
		test_unreachable_field();
		test_negative_match();
		test_mixed_settings();

		wait_results();
		if (fail_count == 0)
			$display("framed_field_match_parser verification clean");
		else
			$display("framed_field_match_parser verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ffmp_pkg.sv
hdl/ffmp_front.sv
hdl/ffmp_queue.sv
hdl/ffmp_back.sv
hdl/framed_field_match_parser.sv
dv/framed_field_match_parser_test.sv
